FILE: design/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int LEVEL_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS   = 6;

  localparam int HUE_W = 15;
  localparam int LVL_W = 13;
  localparam int CH_W  = 8;

  localparam int LV_W    = LEVEL_FRAC_BITS + 1;
  localparam int LVL_ONE = 1 << LEVEL_FRAC_BITS;

  localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int REM_W       = $clog2(SECTOR_SPAN);
  localparam int NSEG        = ((1 << HUE_W) - 1) / SECTOR_SPAN;
  localparam int SEG_W       = (NSEG < 1) ? 1 : $clog2(NSEG + 1);

  // sector span is 15 * 2^(HUE_FRAC_BITS + 2)
  localparam int SPAN_DIV = 15;
  localparam int SH_UP    = (LEVEL_FRAC_BITS >= HUE_FRAC_BITS + 2) ?
                            (LEVEL_FRAC_BITS - HUE_FRAC_BITS - 2) : 0;
  localparam int SH_DN    = (LEVEL_FRAC_BITS >= HUE_FRAC_BITS + 2) ?
                            0 : (HUE_FRAC_BITS + 2 - LEVEL_FRAC_BITS);
  localparam int XW       = LEVEL_FRAC_BITS + 4;
  localparam int RECIP    = (1 << XW) / SPAN_DIV;

  localparam int SECT_W = 3;
  typedef logic [SECT_W-1:0] sector_t;

  localparam sector_t SECT_RED_YEL = 3'd0;
  localparam sector_t SECT_YEL_GRN = 3'd1;
  localparam sector_t SECT_GRN_CYN = 3'd2;
  localparam sector_t SECT_CYN_BLU = 3'd3;
  localparam sector_t SECT_BLU_MAG = 3'd4;
  localparam sector_t SECT_MAG_RED = 3'd5;

  typedef logic [LV_W-1:0]            lvl_t;
  typedef logic [LEVEL_FRAC_BITS-1:0] frac_t;

  typedef struct packed {
    logic             valid;
    logic [HUE_W-1:0] hue;
    logic [LVL_W-1:0] saturation;
    logic [LVL_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic    valid;
    sector_t sector;
    frac_t   frac;
    lvl_t    sat;
    lvl_t    val;
  } hue_out_t;

  typedef struct packed {
    logic    valid;
    sector_t sector;
    lvl_t    lv;
    lvl_t    lp;
    lvl_t    lq;
    lvl_t    lt;
  } lvl_out_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  function automatic lvl_t clamp_level(input logic [LVL_W-1:0] x);
    if (int'(x) > LVL_ONE) begin
      return LV_W'(LVL_ONE);
    end
    return LV_W'(x);
  endfunction

endpackage

FILE: design/hsvrgb_if.sv
interface hsvrgb_hsv_if import hsvrgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [LVL_W-1:0] saturation;
  logic [LVL_W-1:0] brightness;

  modport source(output valid, output hue, output saturation, output brightness,
                 input ready);
  modport sink(input valid, input hue, input saturation, input brightness,
               output ready);
endinterface

interface hsvrgb_rgb_if import hsvrgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

FILE: design/hsvrgb_sector.sv
module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  hsv_t     in_item,
  output logic     in_ready,
  output hue_out_t out_item,
  input  logic     out_ready
);

  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  logic             s1_v_r;
  logic [SEG_W-1:0] s1_seg_r;
  logic [HUE_W-1:0] s1_hue_r;
  lvl_t             s1_sat_r, s1_val_r;
  logic [SEG_W-1:0] seg_nxt;

  logic          s2_v_r;
  sector_t       s2_sect_r;
  logic [XW-1:0] s2_x_r;
  lvl_t          s2_sat_r, s2_val_r;
  sector_t       sect_nxt;
  logic [XW-1:0] x_nxt;

  logic          s3_v_r;
  sector_t       s3_sect_r;
  logic [XW-1:0] s3_x_r;
  frac_t         s3_q0_r;
  lvl_t          s3_sat_r, s3_val_r;
  frac_t         q0_nxt;

  logic    s4_v_r;
  sector_t s4_sect_r;
  frac_t   s4_frac_r;
  lvl_t    s4_sat_r, s4_val_r;
  frac_t   frac_nxt;

  assign s4_rdy   = !s4_v_r || out_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // stage 1: segment count by compare against sector boundaries
  always_comb begin
    seg_nxt = '0;
    for (int k = 1; k <= NSEG; k++) begin
      if (int'(in_item.hue) >= k * SECTOR_SPAN) begin
        seg_nxt = SEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_item.valid) begin
      s1_seg_r <= seg_nxt;
      s1_hue_r <= in_item.hue;
      s1_sat_r <= clamp_level(in_item.saturation);
      s1_val_r <= clamp_level(in_item.brightness);
    end
  end

  // stage 2: remainder in sector and wrap to six sectors
  always_comb begin
    logic [HUE_W-1:0]       base;
    logic [REM_W-1:0]       rem;
    logic [XW+REM_W-1:0]    wide;
    base     = '0;
    sect_nxt = SECT_RED_YEL;
    for (int i = 0; i <= NSEG; i++) begin
      if (s1_seg_r == SEG_W'(i)) begin
        base     = HUE_W'(i * SECTOR_SPAN);
        sect_nxt = SECT_W'(i % 6);
      end
    end
    rem   = REM_W'(s1_hue_r - base);
    wide  = (XW + REM_W)'(rem) << SH_UP;
    x_nxt = XW'(wide >> SH_DN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_sect_r <= sect_nxt;
      s2_x_r    <= x_nxt;
      s2_sat_r  <= s1_sat_r;
      s2_val_r  <= s1_val_r;
    end
  end

  // stage 3: reciprocal multiply, estimate is exact or one low
  always_comb begin
    logic [2*XW-1:0] prod;
    prod   = (2 * XW)'(s2_x_r) * (2 * XW)'(RECIP);
    q0_nxt = prod[XW+LEVEL_FRAC_BITS-1:XW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_sect_r <= s2_sect_r;
      s3_x_r    <= s2_x_r;
      s3_q0_r   <= q0_nxt;
      s3_sat_r  <= s2_sat_r;
      s3_val_r  <= s2_val_r;
    end
  end

  // stage 4: quotient correction
  always_comb begin
    logic [XW-1:0] r;
    r = s3_x_r - (XW'(s3_q0_r) << 4) + XW'(s3_q0_r);
    if (r >= XW'(SPAN_DIV)) begin
      frac_nxt = s3_q0_r + frac_t'(1);
    end else begin
      frac_nxt = s3_q0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_sect_r <= s3_sect_r;
      s4_frac_r <= frac_nxt;
      s4_sat_r  <= s3_sat_r;
      s4_val_r  <= s3_val_r;
    end
  end

  assign out_item.valid  = s4_v_r;
  assign out_item.sector = s4_sect_r;
  assign out_item.frac   = s4_frac_r;
  assign out_item.sat    = s4_sat_r;
  assign out_item.val    = s4_val_r;

endmodule

FILE: design/hsvrgb_levels.sv
module hsvrgb_levels import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  hue_out_t in_item,
  output logic     in_ready,
  output lvl_out_t out_item,
  input  logic     out_ready
);

  localparam int PW = 2 * LV_W;
  localparam lvl_t ONE_LV = LV_W'(LVL_ONE);

  logic s5_rdy, s6_rdy;

  logic    s5_v_r;
  sector_t s5_sect_r;
  lvl_t    s5_v_lvl_r, s5_p_r, s5_sf_r, s5_sg_r;
  lvl_t    p_nxt, sf_nxt, sg_nxt;

  logic    s6_v_r;
  sector_t s6_sect_r;
  lvl_t    s6_v_lvl_r, s6_p_r, s6_q_r, s6_t_r;
  lvl_t    q_nxt, t_nxt;

  assign s6_rdy   = !s6_v_r || out_ready;
  assign s5_rdy   = !s5_v_r || s6_rdy;
  assign in_ready = s5_rdy;

  // stage 5: p, s*f and s*(1-f)
  always_comb begin
    logic [PW-1:0] pp, pf, pg;
    lvl_t          f_lv;
    f_lv   = LV_W'(in_item.frac);
    pp     = PW'(in_item.val) * PW'(ONE_LV - in_item.sat);
    pf     = PW'(in_item.sat) * PW'(f_lv);
    pg     = PW'(in_item.sat) * PW'(ONE_LV - f_lv);
    p_nxt  = LV_W'(pp >> LEVEL_FRAC_BITS);
    sf_nxt = LV_W'(pf >> LEVEL_FRAC_BITS);
    sg_nxt = LV_W'(pg >> LEVEL_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && in_item.valid) begin
      s5_sect_r  <= in_item.sector;
      s5_v_lvl_r <= in_item.val;
      s5_p_r     <= p_nxt;
      s5_sf_r    <= sf_nxt;
      s5_sg_r    <= sg_nxt;
    end
  end

  // stage 6: q and t
  always_comb begin
    logic [PW-1:0] pq, pt;
    pq    = PW'(s5_v_lvl_r) * PW'(ONE_LV - s5_sf_r);
    pt    = PW'(s5_v_lvl_r) * PW'(ONE_LV - s5_sg_r);
    q_nxt = LV_W'(pq >> LEVEL_FRAC_BITS);
    t_nxt = LV_W'(pt >> LEVEL_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_rdy) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy && s5_v_r) begin
      s6_sect_r  <= s5_sect_r;
      s6_v_lvl_r <= s5_v_lvl_r;
      s6_p_r     <= s5_p_r;
      s6_q_r     <= q_nxt;
      s6_t_r     <= t_nxt;
    end
  end

  assign out_item.valid  = s6_v_r;
  assign out_item.sector = s6_sect_r;
  assign out_item.lv     = s6_v_lvl_r;
  assign out_item.lp     = s6_p_r;
  assign out_item.lq     = s6_q_r;
  assign out_item.lt     = s6_t_r;

endmodule

FILE: design/hsvrgb_pack.sv
module hsvrgb_pack import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  lvl_out_t in_item,
  output logic     in_ready,
  output rgb_t     out_item,
  input  logic     out_ready
);

  logic            s7_rdy;
  logic            s7_v_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;

  function automatic logic [CH_W-1:0] to_byte(input lvl_t lvl);
    logic [LV_W+7:0] m;
    logic [8:0]      c;
    m = (LV_W + 8)'({lvl, 8'b0}) - (LV_W + 8)'(lvl);
    c = m[LEVEL_FRAC_BITS+8:LEVEL_FRAC_BITS];
    if (c[8]) begin
      return 8'hff;
    end
    return c[7:0];
  endfunction

  assign s7_rdy   = !s7_v_r || out_ready;
  assign in_ready = s7_rdy;

  always_comb begin
    lvl_t r, g, b;
    case (in_item.sector)
      SECT_RED_YEL: begin r = in_item.lv; g = in_item.lt; b = in_item.lp; end
      SECT_YEL_GRN: begin r = in_item.lq; g = in_item.lv; b = in_item.lp; end
      SECT_GRN_CYN: begin r = in_item.lp; g = in_item.lv; b = in_item.lt; end
      SECT_CYN_BLU: begin r = in_item.lp; g = in_item.lq; b = in_item.lv; end
      SECT_BLU_MAG: begin r = in_item.lt; g = in_item.lp; b = in_item.lv; end
      default: begin r = in_item.lv; g = in_item.lp; b = in_item.lq; end
    endcase
    red_nxt   = to_byte(r);
    green_nxt = to_byte(g);
    blue_nxt  = to_byte(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (s7_rdy) begin
      s7_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_rdy && in_item.valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_item.valid = s7_v_r;
  assign out_item.red   = red_r;
  assign out_item.green = green_r;
  assign out_item.blue  = blue_r;

endmodule

FILE: design/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter, seven register stages
// path: an item accepted at the input is registered in stages s1 through s7 in turn before it reaches out_pix
// throughput: one item per cycle while out_pix.ready is held high, set by the fully pipelined datapath
// stages: 4 for hue split and fraction, 2 for level products, 1 for channel pack
// reset: rst_n synchronous active low, clears stage valid bits only
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  hsvrgb_hsv_if.sink         in_pix,
  hsvrgb_rgb_if.source       out_pix
);

  hsv_t     hsv_item;
  hue_out_t hue_item;
  lvl_out_t lvl_item;
  rgb_t     rgb_item;
  logic     sec_ready, lvl_ready, pack_ready;

  assign hsv_item.valid      = in_pix.valid;
  assign hsv_item.hue        = in_pix.hue;
  assign hsv_item.saturation = in_pix.saturation;
  assign hsv_item.brightness = in_pix.brightness;
  assign in_pix.ready        = sec_ready;

  hsvrgb_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (hsv_item),
    .in_ready  (sec_ready),
    .out_item  (hue_item),
    .out_ready (lvl_ready)
  );

  hsvrgb_levels u_levels (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (hue_item),
    .in_ready  (lvl_ready),
    .out_item  (lvl_item),
    .out_ready (pack_ready)
  );

  hsvrgb_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (lvl_item),
    .in_ready  (pack_ready),
    .out_item  (rgb_item),
    .out_ready (out_pix.ready)
  );

  assign out_pix.valid = rgb_item.valid;
  assign out_pix.red   = rgb_item.red;
  assign out_pix.green = rgb_item.green;
  assign out_pix.blue  = rgb_item.blue;

endmodule

FILE: tb/sv/hsvrgb_checker.sv
`timescale 1ns / 100ps

module hsvrgb_checker import hsvrgb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  hsvrgb_hsv_if in_ch,
  hsvrgb_rgb_if out_ch,
  output int    mismatches,
  output int    pending
);

  localparam longint unsigned ONE_LVL = LVL_ONE;
  localparam longint unsigned SPAN    = SECTOR_SPAN;
  localparam longint unsigned CIRCLE  = SECTOR_SPAN * 6;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_rgb_t;

  pixel_rgb_t expected_pixels[$];
  int         fail_total = 0;

  function automatic logic [CH_W-1:0] level_to_byte(input longint unsigned level);
    longint unsigned c;
    c = (level * 255) >> LEVEL_FRAC_BITS;
    if (c > 255) begin
      c = 255;
    end
    return CH_W'(c);
  endfunction

  function automatic pixel_rgb_t convert_hsv(input logic [HUE_W-1:0] hue,
                                             input logic [LVL_W-1:0] sat_in,
                                             input logic [LVL_W-1:0] bri_in);
    longint unsigned h, s, v, sector, rem, f, sf, sg, p, q, t, r, g, b;
    pixel_rgb_t px;
    h = longint'(hue) % CIRCLE;
    s = (longint'(sat_in) > ONE_LVL) ? ONE_LVL : longint'(sat_in);
    v = (longint'(bri_in) > ONE_LVL) ? ONE_LVL : longint'(bri_in);
    sector = h / SPAN;
    rem = h % SPAN;
    f = (rem << LEVEL_FRAC_BITS) / SPAN;
    sf = (s * f) >> LEVEL_FRAC_BITS;
    sg = (s * (ONE_LVL - f)) >> LEVEL_FRAC_BITS;
    p = (v * (ONE_LVL - s)) >> LEVEL_FRAC_BITS;
    q = (v * (ONE_LVL - sf)) >> LEVEL_FRAC_BITS;
    t = (v * (ONE_LVL - sg)) >> LEVEL_FRAC_BITS;
    case (sector_t'(sector))
      SECT_RED_YEL: begin
        r = v; g = t; b = p;
      end
      SECT_YEL_GRN: begin
        r = q; g = v; b = p;
      end
      SECT_GRN_CYN: begin
        r = p; g = v; b = t;
      end
      SECT_CYN_BLU: begin
        r = p; g = q; b = v;
      end
      SECT_BLU_MAG: begin
        r = t; g = p; b = v;
      end
      default: begin
        r = v; g = p; b = q;
      end
    endcase
    px.red   = level_to_byte(r);
    px.green = level_to_byte(g);
    px.blue  = level_to_byte(b);
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_rgb_t want;
    pixel_rgb_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.red   = out_ch.red;
        got.green = out_ch.green;
        got.blue  = out_ch.blue;
        if (expected_pixels.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("%0t: unexpected item r=%0d g=%0d b=%0d", $realtime,
                     got.red, got.green, got.blue);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue) begin
            fail_total++;
            if (fail_total <= REPORT_MAX) begin
              $display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_pixels.push_back(convert_hsv(in_ch.hue, in_ch.saturation,
                                              in_ch.brightness));
      end
    end
    mismatches <= fail_total;
    pending    <= expected_pixels.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hsvrgb_pkg::*;

  localparam int RANDOM_PIXELS = 1850;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_AT       = 700;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CIRCLE        = SECTOR_SPAN * 6;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [LVL_W-1:0] saturation;
    logic [LVL_W-1:0] brightness;
  } hsv_item_t;

  typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_MOSTLY, FLOW_BEAT} flow_t;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   pixels_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  bit   hold_done = 1'b0;

  hsv_item_t directed_pixels[22] = '{
    '{15'd0,     13'd4096, 13'd4096},
    '{15'd3840,  13'd4096, 13'd4096},
    '{15'd7680,  13'd4096, 13'd4096},
    '{15'd11520, 13'd4096, 13'd4096},
    '{15'd15360, 13'd4096, 13'd4096},
    '{15'd19200, 13'd4096, 13'd4096},
    '{15'd23040, 13'd4096, 13'd4096},
    '{15'd23039, 13'd4096, 13'd4096},
    '{15'd32767, 13'd4096, 13'd4096},
    '{15'd3839,  13'd4096, 13'd4096},
    '{15'd1,     13'd4096, 13'd4096},
    '{15'd1920,  13'd2048, 13'd4096},
    '{15'd0,     13'd0,    13'd4096},
    '{15'd0,     13'd0,    13'd0},
    '{15'd12000, 13'd4096, 13'd0},
    '{15'd5000,  13'd8191, 13'd8191},
    '{15'd9000,  13'd4097, 13'd4097},
    '{15'd17000, 13'd3000, 13'd2500},
    '{15'd21000, 13'd1,    13'd4095},
    '{15'd0,     13'd0,    13'd8191},
    '{15'd20000, 13'd8191, 13'd100},
    '{15'd16383, 13'd4095, 13'd4096}
  };

  hsvrgb_hsv_if in_ch();
  hsvrgb_rgb_if out_ch();

  hsv_to_rgb_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_ch),
    .out_pix (out_ch)
  );

  hsvrgb_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [LVL_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LVL_W'(LVL_ONE);
      default: return LVL_W'($urandom_range(0, LVL_ONE));
    endcase
  endfunction

  function automatic hsv_item_t random_pixel();
    hsv_item_t px;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      // raw noise over the full field widths
      px.hue        = HUE_W'($urandom);
      px.saturation = LVL_W'($urandom);
      px.brightness = LVL_W'($urandom);
    end else begin
      if (pick < 6) begin
        px.hue = HUE_W'(SECTOR_SPAN * $urandom_range(0, 6) + $urandom_range(0, 2));
        px.hue = (px.hue == 0) ? px.hue : px.hue - 1'b1;
      end else begin
        px.hue = HUE_W'($urandom_range(0, CIRCLE));
      end
      px.saturation = random_level();
      px.brightness = random_level();
    end
    return px;
  endfunction

  task automatic offer_pixel(input hsv_item_t px);
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= px.hue;
    in_ch.saturation <= px.saturation;
    in_ch.brightness <= px.brightness;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 30);
    end
  endtask

  // sender
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.hue        <= '0;
    in_ch.saturation <= '0;
    in_ch.brightness <= '0;
    rst_n            <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_pixels[i]) begin
      offer_pixel(directed_pixels[i]);
    end
    repeat (RANDOM_PIXELS) begin
      offer_pixel(random_pixel());
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("hsv_to_rgb_converter: match");
    end else begin
      $display("hsv_to_rgb_converter: mismatch");
    end
    $finish;
  end

  // receiver
  initial begin
    flow_t flow;
    int    span;
    int    tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && pixels_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        flow = flow_t'($urandom_range(0, 3));
        span = $urandom_range(4, 60);
        repeat (span) begin
          tick++;
          case (flow)
            FLOW_FREE:   out_ch.ready <= 1'b1;
            FLOW_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            FLOW_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default:     out_ch.ready <= ((tick % 5) < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("hsv_to_rgb_converter: mismatch");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
design/hsvrgb_pkg.sv
design/hsvrgb_if.sv
design/hsvrgb_sector.sv
design/hsvrgb_levels.sv
design/hsvrgb_pack.sv
design/hsv_to_rgb_converter.sv
tb/sv/hsvrgb_checker.sv
tb/sv/testbench.sv
